// File: hw/rtl/cfc_pkg.sv
// Shared types, constants and helper functions for the coordinate frame converter.
// Depends on nothing; imported by the top-level converter by wildcard import.
`timescale 1ns / 1ps

package cfc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int CORDIC_ITERATIONS_DEF = 24;
    localparam int GUARD = 16;
    localparam int TABLE_LEN = 40;
    // Internal datapath width: Q16.16 plus guard bits plus CORDIC growth.
    localparam int DW = 52;

    localparam logic [31:0] KINV = 32'h9B74EDA8;
    localparam logic [31:0] HALF_TURN = 32'h80000000;
    localparam logic [31:0] QUARTER_TURN = 32'h40000000;

    typedef enum logic [1:0] {
        FRAME_CART = 2'd0,
        FRAME_SPH  = 2'd1,
        FRAME_CYL  = 2'd2,
        FRAME_BAD  = 2'd3
    } frame_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] radius;
        logic [31:0]        polar_angle;
        logic [31:0]        azimuth;
        logic signed [31:0] cyl_radius;
        logic               bad_frame;
    } out_req_t;

    // Arctangent table in binary angle units.
    function automatic logic [31:0] atan_lut(input int i);
        logic [31:0] t;
        begin
            case (i)
                0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
                3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
                6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
                9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
                12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
                15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
                18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
                21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
                24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
                27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
                30: t = 32'h00000001;
                default: t = 32'h0;
            endcase
            atan_lut = t;
        end
    endfunction

endpackage

// File: hw/rtl/coordinate_frame_converter.sv
// Top level of the coordinate frame converter.
// Throughput: one request per cycle; a stall freezes the whole pipeline in place.
// The pipeline holds two unrolled CORDIC passes, one iteration per register stage.
// Reset (rst_n, asynchronous, active low) clears all valid bits; payload is not reset.
// Depends on cfc_pkg and cfc_stage.
`timescale 1ns / 1ps

module coordinate_frame_converter
    import cfc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_req_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output out_req_t out_data
);

    localparam int NIT = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
    localparam longint LMAX_W = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint LMAX = (LMAX_W > 64'sd2147483647) ? 64'sd2147483647 : LMAX_W;

    typedef logic signed [DW-1:0] d_t;

    // Stage-global advance: the whole pipe moves unless output is held
    logic adv;
    assign adv = !out_valid || out_ready;
    assign in_ready = adv;

    function automatic d_t sat_len(input d_t v);
        begin
            if (v > d_t'(LMAX)) sat_len = d_t'(LMAX);
            else if (v < d_t'(-LMAX - 1)) sat_len = d_t'(-LMAX - 1);
            else sat_len = v;
        end
    endfunction

    function automatic d_t out_len(input d_t g);
        d_t t;
        begin
            t = (g + d_t'(64'sd1 <<< (GUARD - 1))) >>> GUARD;
            out_len = sat_len(t);
        end
    endfunction

    function automatic d_t dabs(input d_t v);
        begin
            dabs = v[DW-1] ? -v : v;
        end
    endfunction

    // Carried context shared by all passes
    typedef struct packed {
        logic [1:0]  func;
        d_t          la;     // saturated length a (x, r, rho)
        d_t          lb;     // saturated length b (y)
        d_t          lc;     // saturated length c (z)
        logic [31:0] theta;
        logic [31:0] phi;
    } ctx_t;

    // CORDIC working set
    typedef struct packed {
        d_t          x;
        d_t          y;
        logic signed [33:0] z;
        logic [1:0]  mode;   // 0 bypass, 1 vectoring, 2 rotation
        d_t          bc;     // bypass cos / magnitude
        d_t          bs;     // bypass sin
        logic [31:0] ba;     // bypass / base angle
    } cw_t;

    localparam int CTXW = $bits(ctx_t);
    localparam int CWW = $bits(cw_t);
    localparam int SW = CTXW + CWW;

    localparam logic [1:0] M_BYP = 2'd0;
    localparam logic [1:0] M_VEC = 2'd1;
    localparam logic [1:0] M_ROT = 2'd2;

    // ---------------- stage 0: input saturation and angle fold
    ctx_t c0;
    always_comb
    begin
        c0.func = in_data.func;
        c0.la = sat_len(d_t'(in_data.coord_a));
        c0.lb = sat_len(d_t'(in_data.coord_b));
        c0.lc = sat_len(d_t'(in_data.coord_c));
        c0.theta = in_data.coord_b;
        c0.phi = (in_data.func == FRAME_SPH) ? in_data.coord_c : in_data.coord_b;
        if (in_data.func == FRAME_SPH && in_data.coord_b > HALF_TURN)
        begin
            c0.theta = 32'd0 - in_data.coord_b;
            c0.phi = in_data.coord_c + HALF_TURN;
        end
    end

    logic v1;
    ctx_t c1;
    cfc_stage #(.W(CTXW)) u_s0 (
        .clk(clk), .rst_n(rst_n), .en(adv), .vin(in_valid && in_ready),
        .din(c0), .vout(v1), .dout(c1)
    );

    // Prepare a CORDIC pass: vectoring on (x,y) or rotation of m by a
    function automatic cw_t prep_vec(input d_t x, input d_t y);
        cw_t w;
        begin
            w = '0;
            w.mode = M_VEC;
            if (y == 0)
            begin
                w.mode = M_BYP; w.bc = dabs(x); w.ba = x[DW-1] ? HALF_TURN : 32'd0;
            end
            else if (x == 0)
            begin
                w.mode = M_BYP; w.bc = dabs(y);
                w.ba = y[DW-1] ? (HALF_TURN | QUARTER_TURN) : QUARTER_TURN;
            end
            else if (x[DW-1])
            begin
                w.x = -x; w.y = -y; w.z = 34'sd2147483648;
            end
            else
            begin
                w.x = x; w.y = y; w.z = '0;
            end
            prep_vec = w;
        end
    endfunction

    // Rotation prep without gain scale (scale applied in separate stages)
    function automatic cw_t prep_rot(input d_t m, input logic [31:0] a);
        cw_t w;
        logic [31:0] aa;
        d_t mm;
        begin
            w = '0;
            w.mode = M_ROT;
            mm = m;
            aa = a;
            if (a[29:0] == 30'd0)
            begin
                w.mode = M_BYP;
                case (a[31:30])
                    2'd0: begin w.bc = m; w.bs = '0; end
                    2'd1: begin w.bc = '0; w.bs = m; end
                    2'd2: begin w.bc = -m; w.bs = '0; end
                    default: begin w.bc = '0; w.bs = -m; end
                endcase
            end
            else
            begin
                if (((a + QUARTER_TURN) & HALF_TURN) != 0)
                begin
                    mm = -m; aa = a + HALF_TURN;
                end
                w.x = mm;
                w.z = {{2{aa[31]}}, aa};
            end
            prep_rot = w;
        end
    endfunction

    // mulk on magnitude: (a*KINV + 2^31) >> 32, a split at bit 24.
    // Low part: rounding carry from the low 8 bits of the high product
    // plus the upper bits of the low product.
    function automatic d_t mulk_lo(input d_t a);
        logic [55:0] u;
        logic [15:0] tl;
        logic [32:0] s;
        begin
            u = {32'd0, a[23:0]} * {24'd0, KINV};
            tl = {8'd0, a[31:24]} * {8'd0, KINV[7:0]};
            s = {25'd0, tl[7:0]} + {1'b0, u[55:24]} + 33'd128;
            mulk_lo = d_t'({19'd0, s});
        end
    endfunction

    // High part: high product already shifted down by 8
    function automatic d_t mulk_hi(input d_t a);
        logic [59:0] t;
        begin
            t = {32'd0, a[DW-2:24]} * {28'd0, KINV};
            mulk_hi = d_t'(t[59:8]);
        end
    endfunction

    // Combine partial results: t = hi, u = lo
    function automatic d_t mulk_fin(input d_t t, input d_t u);
        begin
            mulk_fin = t + (u >>> 8);
        end
    endfunction

    // One CORDIC iteration
    function automatic cw_t cstep(input cw_t w, input int i);
        cw_t o;
        d_t xs, ys;
        logic signed [33:0] at;
        begin
            o = w;
            xs = w.x >>> i;
            ys = w.y >>> i;
            at = {2'b00, atan_lut(i)};
            if (w.mode == M_VEC)
            begin
                if (!w.y[DW-1] && w.y != 0)
                begin
                    o.x = w.x + ys; o.y = w.y - xs; o.z = w.z + at;
                end
                else
                begin
                    o.x = w.x - ys; o.y = w.y + xs; o.z = w.z - at;
                end
            end
            else if (w.mode == M_ROT)
            begin
                if (!w.z[33])
                begin
                    o.x = w.x - ys; o.y = w.y + xs; o.z = w.z - at;
                end
                else
                begin
                    o.x = w.x + ys; o.y = w.y - xs; o.z = w.z + at;
                end
            end
            cstep = o;
        end
    endfunction

    // ---------------- pass A: phi vectoring (cart) or theta rotation (sph)
    // Cylindrical uses pass A for the phi rotation.
    cw_t wa0;
    always_comb
    begin
        case (c1.func)
            FRAME_CART: wa0 = prep_vec(c1.la <<< GUARD, c1.lb <<< GUARD);
            FRAME_SPH:  wa0 = prep_rot(c1.la <<< GUARD, c1.theta);
            default:    wa0 = prep_rot(c1.la <<< GUARD, c1.phi);
        endcase
    end

    // Gain prescale for rotation passes: two stages (partial products, combine)
    logic [SW-1:0] pa_d [0:NIT+2];
    logic          pa_v [0:NIT+2];
    logic [SW-1:0] ga_in;
    always_comb
    begin
        ga_in = {c1, wa0};
    end

    // Pre-stage 1: partial products of |x|, sign in bs
    function automatic logic [SW-1:0] pre1(input logic [SW-1:0] s);
        ctx_t c; cw_t w; d_t ax;
        begin
            {c, w} = s;
            if (w.mode == M_ROT)
            begin
                ax = dabs(w.x);
                w.bs = w.x;                 // keep sign
                w.bc = mulk_lo(ax);
                w.x = mulk_hi(ax);
            end
            pre1 = {c, w};
        end
    endfunction

    function automatic logic [SW-1:0] pre2(input logic [SW-1:0] s);
        ctx_t c; cw_t w; d_t r;
        begin
            {c, w} = s;
            if (w.mode == M_ROT)
            begin
                r = mulk_fin(w.x, w.bc);
                w.x = w.bs[DW-1] ? -r : r;
                w.bc = '0; w.bs = '0;
            end
            pre2 = {c, w};
        end
    endfunction

    function automatic logic [SW-1:0] iter(input logic [SW-1:0] s, input int i);
        ctx_t c; cw_t w;
        begin
            {c, w} = s;
            iter = {c, cstep(w, i)};
        end
    endfunction

    assign pa_d[0] = ga_in;
    assign pa_v[0] = v1;

    cfc_stage #(.W(SW)) u_pa1 (.clk(clk), .rst_n(rst_n), .en(adv), .vin(pa_v[0]),
        .din(pre1(pa_d[0])), .vout(pa_v[1]), .dout(pa_d[1]));
    cfc_stage #(.W(SW)) u_pa2 (.clk(clk), .rst_n(rst_n), .en(adv), .vin(pa_v[1]),
        .din(pre2(pa_d[1])), .vout(pa_v[2]), .dout(pa_d[2]));

    genvar gi;
    generate
        for (gi = 0; gi < NIT; gi++)
        begin : g_pa
            cfc_stage #(.W(SW)) u_it (.clk(clk), .rst_n(rst_n), .en(adv),
                .vin(pa_v[gi+2]), .din(iter(pa_d[gi+2], gi)),
                .vout(pa_v[gi+3]), .dout(pa_d[gi+3]));
        end
    endgenerate

    // Finish a pass: returns (c, s, angle). For vectoring c = magnitude.
    // Vectoring magnitude needs mulk too; done as two stages after the loop.
    typedef struct packed {
        d_t          rc;
        d_t          rs;
        logic [31:0] ang;
    } pres_t;

    function automatic logic [SW-1:0] post1(input logic [SW-1:0] s);
        ctx_t c; cw_t w; d_t ax;
        begin
            {c, w} = s;
            if (w.mode == M_VEC)
            begin
                ax = w.x[DW-1] ? d_t'(0) : w.x;
                w.ba = w.z[31:0];
                w.bc = mulk_lo(ax);
                w.bs = mulk_hi(ax);
            end
            post1 = {c, w};
        end
    endfunction

    function automatic pres_t post2(input cw_t w);
        pres_t p;
        begin
            p.ang = w.ba;
            p.rc = w.bc;
            p.rs = w.bs;
            if (w.mode == M_VEC)
            begin
                p.rc = mulk_fin(w.bs, w.bc);
                p.rs = '0;
            end
            else if (w.mode == M_ROT)
            begin
                p.rc = w.x;
                p.rs = w.y;
            end
            post2 = p;
        end
    endfunction

    logic [SW-1:0] qa;
    logic          qa_v;
    cfc_stage #(.W(SW)) u_qa (.clk(clk), .rst_n(rst_n), .en(adv), .vin(pa_v[NIT+2]),
        .din(post1(pa_d[NIT+2])), .vout(qa_v), .dout(qa));

    // After pass A: results feed pass B
    // cart: rho = mag, phi = angle; sph: zg = c, rhog = s; cyl: xg = c, yg = s
    typedef struct packed {
        ctx_t c;
        d_t   r1;    // cart rhog, sph zg, cyl xg
        d_t   r2;    // sph rhog, cyl yg
    } mid_t;
    localparam int MW = $bits(mid_t);

    mid_t m0;
    always_comb
    begin
        ctx_t c; cw_t w; pres_t p;
        {c, w} = qa;
        p = post2(w);
        m0.c = c;
        m0.r1 = p.rc;
        m0.r2 = p.rs;
        if (c.func == FRAME_CART)
        begin
            m0.c.phi = p.ang;
        end
    end

    logic m1_v;
    mid_t m1;
    cfc_stage #(.W(MW)) u_ma (.clk(clk), .rst_n(rst_n), .en(adv), .vin(qa_v),
        .din(m0), .vout(m1_v), .dout(m1));

    // ---------------- pass B: polar vectoring (cart, cyl) or phi rotation (sph)
    cw_t wb0;
    always_comb
    begin
        case (m1.c.func)
            FRAME_SPH: wb0 = prep_rot(m1.r2, m1.c.phi);
            FRAME_CART:
            begin
                if (m1.r1 == 0)
                begin
                    wb0 = '0; wb0.mode = M_BYP; wb0.bc = dabs(m1.c.lc <<< GUARD);
                    wb0.ba = m1.c.lc[DW-1] ? HALF_TURN : 32'd0;
                end
                else wb0 = prep_vec(m1.c.lc <<< GUARD, dabs(m1.r1));
            end
            default:
            begin
                if (m1.c.la == 0)
                begin
                    wb0 = '0; wb0.mode = M_BYP; wb0.bc = dabs(m1.c.lc <<< GUARD);
                    wb0.ba = m1.c.lc[DW-1] ? HALF_TURN : 32'd0;
                end
                else wb0 = prep_vec(m1.c.lc <<< GUARD, dabs(m1.c.la <<< GUARD));
            end
        endcase
    end

    // Carry pass-A results through pass B alongside the context
    typedef struct packed {
        d_t  r1;
        d_t  r2;
        ctx_t c;
        cw_t w;
    } pb_t;
    localparam int PBW = $bits(pb_t);

    function automatic logic [PBW-1:0] bwrap1(input logic [PBW-1:0] s);
        pb_t p;
        begin
            p = s;
            {p.c, p.w} = pre1({p.c, p.w});
            bwrap1 = p;
        end
    endfunction
    function automatic logic [PBW-1:0] bwrap2(input logic [PBW-1:0] s);
        pb_t p;
        begin
            p = s;
            {p.c, p.w} = pre2({p.c, p.w});
            bwrap2 = p;
        end
    endfunction
    function automatic logic [PBW-1:0] bwrapi(input logic [PBW-1:0] s, input int i);
        pb_t p;
        begin
            p = s;
            p.w = cstep(p.w, i);
            bwrapi = p;
        end
    endfunction
    function automatic logic [PBW-1:0] bwrapq(input logic [PBW-1:0] s);
        pb_t p;
        begin
            p = s;
            {p.c, p.w} = post1({p.c, p.w});
            bwrapq = p;
        end
    endfunction

    pb_t pb_in;
    always_comb
    begin
        pb_in.r1 = m1.r1;
        pb_in.r2 = m1.r2;
        pb_in.c = m1.c;
        pb_in.w = wb0;
    end

    logic [PBW-1:0] pb_d [0:NIT+3];
    logic           pb_v [0:NIT+3];
    assign pb_d[0] = pb_in;
    assign pb_v[0] = m1_v;

    cfc_stage #(.W(PBW)) u_pb1 (.clk(clk), .rst_n(rst_n), .en(adv), .vin(pb_v[0]),
        .din(bwrap1(pb_d[0])), .vout(pb_v[1]), .dout(pb_d[1]));
    cfc_stage #(.W(PBW)) u_pb2 (.clk(clk), .rst_n(rst_n), .en(adv), .vin(pb_v[1]),
        .din(bwrap2(pb_d[1])), .vout(pb_v[2]), .dout(pb_d[2]));

    generate
        for (gi = 0; gi < NIT; gi++)
        begin : g_pb
            cfc_stage #(.W(PBW)) u_it (.clk(clk), .rst_n(rst_n), .en(adv),
                .vin(pb_v[gi+2]), .din(bwrapi(pb_d[gi+2], gi)),
                .vout(pb_v[gi+3]), .dout(pb_d[gi+3]));
        end
    endgenerate

    cfc_stage #(.W(PBW)) u_qb (.clk(clk), .rst_n(rst_n), .en(adv), .vin(pb_v[NIT+2]),
        .din(bwrapq(pb_d[NIT+2])), .vout(pb_v[NIT+3]), .dout(pb_d[NIT+3]));

    // ---------------- result assembly
    out_req_t res;
    always_comb
    begin
        pb_t p; pres_t q; logic [31:0] th;
        p = pb_d[NIT+3];
        q = post2(p.w);
        res = '0;
        th = q.ang;
        // clamp theta noise outside [0, pi]
        if (p.w.mode == M_VEC && th > HALF_TURN)
        begin
            th = (th >= (HALF_TURN | QUARTER_TURN)) ? 32'd0 : HALF_TURN;
        end
        case (p.c.func)
            FRAME_CART:
            begin
                res.pos_x = p.c.la[31:0];
                res.pos_y = p.c.lb[31:0];
                res.pos_z = p.c.lc[31:0];
                res.radius = 32'(out_len(q.rc));
                res.cyl_radius = 32'(out_len(p.r1));
                res.polar_angle = th;
                res.azimuth = p.c.phi;
            end
            FRAME_SPH:
            begin
                res.pos_x = 32'(out_len(q.rc));
                res.pos_y = 32'(out_len(q.rs));
                res.pos_z = 32'(out_len(p.r1));
                res.radius = p.c.la[31:0];
                res.cyl_radius = 32'(out_len(p.r2));
                res.polar_angle = p.c.theta;
                res.azimuth = p.c.phi;
            end
            FRAME_CYL:
            begin
                res.pos_x = 32'(out_len(p.r1));
                res.pos_y = 32'(out_len(p.r2));
                res.pos_z = p.c.lc[31:0];
                res.radius = 32'(out_len(q.rc));
                res.cyl_radius = p.c.la[31:0];
                res.polar_angle = th;
                res.azimuth = p.c.phi;
            end
            default:
            begin
                res.bad_frame = 1'b1;
            end
        endcase
    end

    logic [$bits(out_req_t)-1:0] od;
    cfc_stage #(.W($bits(out_req_t))) u_out (.clk(clk), .rst_n(rst_n), .en(adv),
        .vin(pb_v[NIT+3]), .din(res), .vout(out_valid), .dout(od));
    assign out_data = od;

`ifndef ASSERT_OFF
    // Stall must hold the output request
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed during stall");
    // Input is taken whenever the output side is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline blocked without backpressure");
    // Polar angle stays within [0, pi]
    a_theta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.bad_frame && out_data.polar_angle[31] |->
        out_data.polar_angle[30:0] == 31'd0)
        else $error("polar angle beyond pi");
    // Unsupported frame yields zeroed payload
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_frame |-> out_data.radius == 0 && out_data.azimuth == 0)
        else $error("bad frame result not cleared");
`endif

endmodule

// File: hw/rtl/cfc_stage.sv
// One generic register stage with valid bit and stall-aware enable.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module cfc_stage #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         vin,
    input  logic [W-1:0] din,
    output logic         vout,
    output logic [W-1:0] dout
);

    logic         v_reg;
    logic [W-1:0] d_reg;

    // Valid is control; payload only loads when advancing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= din;
        end
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule
